@@ design/gshare_branch_predictor_ras_assert.svh @@
// Assertion macros for the gshare predictor block.
// No dependencies; included by the top level.
`ifndef GSHARE_BRANCH_PREDICTOR_RAS_ASSERT_SVH
`define GSHARE_BRANCH_PREDICTOR_RAS_ASSERT_SVH
`ifndef SYNTHESIS
`define GBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GBP_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBP_ASSERT(label, clk, rst, prop, msg)
`define GBP_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ design/gbp_pkg.sv @@
// Package for the gshare predictor: sizes, codes and shared types.
// No dependencies.
package gbp_pkg;
   localparam int IndexBits = 8;
   localparam int CounterBits = 2;
   localparam int HistBits = 20;
   localparam int StackDepth = 8;
   localparam int StackPtrBits = 3;
   localparam int StackCntBits = 4;
   localparam int QueueDepth = 32;
   localparam int QueuePtrBits = 5;
   localparam int QueueCntBits = 6;
   localparam int TableSize = 256;
   localparam int FallbackTaken = 0;
   localparam int FifoDepth = 2;

   localparam logic [CounterBits-1:0] WeakTaken = CounterBits'(1 << (CounterBits - 1));
   localparam logic [CounterBits-1:0] CounterMax = '1;
   localparam logic [CounterBits-1:0] CounterInit =
      (FallbackTaken != 0) ? WeakTaken : WeakTaken - 1'b1;

   typedef enum logic [1:0] {
      OP_PREDICT = 2'd0, OP_UPDATE = 2'd1, OP_FLUSH = 2'd2, OP_NONE = 2'd3
   } op_type;
   typedef enum logic [1:0] {
      BR_COND = 2'd0, BR_UNCOND = 2'd1, BR_RETURN = 2'd2, BR_CALL = 2'd3
   } branch_type;
   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_FULL = 2'd2, ST_RSVD = 2'd3
   } status_type;
   typedef enum logic [1:0] {
      ACT_NONE = 2'd0, ACT_POP = 2'd1, ACT_PUSH = 2'd2, ACT_RSVD = 2'd3
   } act_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] address;
      branch_type  btype;
      logic [63:0] offset;
      logic        actual_taken;
      logic [63:0] actual_target;
   } item_type;
endpackage

@@ design/gbp_front.sv @@
// Front part: registers incoming items into a short queue.
// Depends on gbp_pkg.
module gbp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  gbp_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_take,
   output gbp_pkg::item_type out_item
);
   import gbp_pkg::*;
   item_type    mem_ff [FifoDepth];
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign in_stall  = (cnt_ff == 2'(FifoDepth));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = mem_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && out_take;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_item;
   end
endmodule

@@ design/gbp_back.sv @@
// Back part: tables, return stack and fetch target queue, one item at a time.
// Depends on gbp_pkg.
module gbp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_take,
   input  gbp_pkg::item_type in_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_predicted_taken,
   output logic [63:0]       rsp_predicted_target,
   output logic [1:0]        rsp_status,
   output logic              busy
);
   import gbp_pkg::*;
   // ctr/tgt tables are memories; a clear sweep runs after reset
   logic [CounterBits-1:0]  ctr_mem [TableSize];
   logic [63:0]             tgt_mem [TableSize];
   logic [63:0]             stk_ff [StackDepth];
   logic [IndexBits:0]      qdi_ff [QueueDepth];
   act_type                 qact_mem [QueueDepth];
   logic [63:0]             qpop_mem [QueueDepth];

   logic [HistBits-1:0]     hist_ff;
   logic [StackPtrBits-1:0] top_ff;
   logic [StackCntBits-1:0] scnt_ff;
   logic [QueuePtrBits-1:0] head_ff;
   logic [QueueCntBits-1:0] qcnt_ff;
   logic [IndexBits:0]      clr_ff;
   logic                    ph_ff;   // 0: read phase, 1: execute phase
   item_type                it_ff;
   logic [IndexBits-1:0]    idx_ff;
   logic [CounterBits-1:0]  crd_ff;
   logic [63:0]             trd_ff;
   logic [IndexBits:0]      qrd_ff;
   act_type                 art_ff;
   logic [63:0]             prd_ff;
   logic                    ov_ff;
   logic                    otk_ff;
   logic [63:0]             otg_ff;
   logic [1:0]              ost_ff;

   logic clearing, start;
   logic [IndexBits-1:0]    idx_a, tbl_idx;
   logic [QueuePtrBits-1:0] tail_slot, young_slot, rd_slot;

   assign clearing = !clr_ff[IndexBits];
   assign start = in_valid && !clearing && !ph_ff && (!ov_ff || !rsp_stall);
   assign in_take = start;
   assign busy = ph_ff || clearing;
   assign rsp_valid = ov_ff;
   assign rsp_predicted_taken = otk_ff;
   assign rsp_predicted_target = otg_ff;
   assign rsp_status = ost_ff;

   assign idx_a = IndexBits'(in_item.address[63:2]) ^ IndexBits'(hist_ff);
   assign tail_slot = head_ff + QueuePtrBits'(qcnt_ff);
   assign young_slot = tail_slot - 1'b1;
   assign rd_slot = (in_item.op == OP_UPDATE) ? head_ff : young_slot;
   // an update trains the counter of its own queue entry, not the one its address hashes to
   assign tbl_idx = (in_item.op == OP_UPDATE) ? qdi_ff[head_ff][IndexBits:1] : idx_a;

   // phase 0: registered reads
   always_ff @(posedge clock) begin
      if (start) begin
         it_ff  <= in_item;
         idx_ff <= idx_a;
         crd_ff <= ctr_mem[tbl_idx];
         trd_ff <= tgt_mem[tbl_idx];
         qrd_ff <= qdi_ff[rd_slot];
         art_ff <= qact_mem[rd_slot];
         prd_ff <= qpop_mem[rd_slot];
      end
   end

   // phase 1 combinational execute
   logic                    tk;
   logic [63:0]             tg;
   act_type                 act;
   logic [63:0]             popv;
   logic                    do_push, do_pop;
   logic [63:0]             push_v;
   logic [StackPtrBits-1:0] top_in, top_m1;
   logic [StackCntBits-1:0] scnt_in;
   logic [HistBits-1:0]     hist_in;
   logic [QueuePtrBits-1:0] head_in;
   logic [QueueCntBits-1:0] qcnt_in, qcnt_dec;
   logic [1:0]              st;
   logic                    q_wr, c_wr, t_wr;
   logic [IndexBits-1:0]    uidx;
   logic [CounterBits-1:0]  cnew;

   always_comb begin
      tk = 1'b0; tg = '0; st = ST_OK; act = ACT_NONE; popv = '0;
      do_push = 1'b0; do_pop = 1'b0; push_v = '0;
      hist_in = hist_ff; head_in = head_ff; qcnt_in = qcnt_ff;
      q_wr = 1'b0; c_wr = 1'b0; t_wr = 1'b0;
      qcnt_dec = qcnt_ff - 1'b1;
      top_m1 = top_ff - 1'b1;
      uidx = qrd_ff[IndexBits:1];
      cnew = crd_ff;
      case (it_ff.op)
         OP_PREDICT: begin
            if (qcnt_ff >= QueueCntBits'(QueueDepth)) begin
               st = ST_FULL;
            end else begin
               tk = (crd_ff >= WeakTaken);
               tg = (it_ff.offset != '0) ? it_ff.address + it_ff.offset : trd_ff;
               case (it_ff.btype)
                  BR_UNCOND: tk = 1'b1;
                  BR_RETURN: begin
                     tk = 1'b1;
                     if (scnt_ff != '0) begin
                        do_pop = 1'b1;
                        popv = stk_ff[top_m1];
                        tg = popv;
                        act = ACT_POP;
                     end
                  end
                  BR_CALL: begin
                     tk = 1'b1;
                     do_push = 1'b1;
                     push_v = it_ff.address + 64'd4;
                     act = ACT_PUSH;
                  end
                  default: if (!tk) tg = it_ff.address + 64'd4;
               endcase
               q_wr = 1'b1;
               qcnt_in = qcnt_ff + 1'b1;
               hist_in = {hist_ff[HistBits-2:0], tk};
            end
         end
         OP_UPDATE: begin
            if (qcnt_ff == '0) begin
               st = ST_EMPTY;
            end else begin
               head_in = head_ff + 1'b1;
               qcnt_in = qcnt_dec;
               c_wr = 1'b1;
               if (it_ff.actual_taken) begin
                  if (crd_ff != CounterMax) cnew = crd_ff + 1'b1;
                  t_wr = 1'b1;
               end else if (crd_ff != '0) begin
                  cnew = crd_ff - 1'b1;
               end
               if (qrd_ff[0] != it_ff.actual_taken && qcnt_dec < QueueCntBits'(HistBits))
                  hist_in[qcnt_dec[$clog2(HistBits)-1:0]] = ~hist_ff[qcnt_dec[$clog2(HistBits)-1:0]];
            end
         end
         OP_FLUSH: begin
            if (qcnt_ff == '0) begin
               st = ST_EMPTY;
            end else begin
               case (art_ff)
                  ACT_POP: begin do_push = 1'b1; push_v = prd_ff; end
                  ACT_PUSH: do_pop = (scnt_ff != '0);
                  default: ;
               endcase
               qcnt_in = qcnt_dec;
               hist_in = hist_ff >> 1;
            end
         end
         default: ;
      endcase
      top_in = top_ff; scnt_in = scnt_ff;
      if (do_push) begin
         top_in = top_ff + 1'b1;
         if (scnt_ff != StackCntBits'(StackDepth)) scnt_in = scnt_ff + 1'b1;
      end else if (do_pop) begin
         top_in = top_m1;
         scnt_in = scnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0; top_ff <= '0; scnt_ff <= '0;
         head_ff <= '0; qcnt_ff <= '0; clr_ff <= '0;
         ph_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         if (clearing) clr_ff <= clr_ff + 1'b1;
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         if (start) ph_ff <= 1'b1;
         if (ph_ff) begin
            ph_ff <= 1'b0;
            ov_ff <= 1'b1;
            hist_ff <= hist_in; top_ff <= top_in; scnt_ff <= scnt_in;
            head_ff <= head_in; qcnt_ff <= qcnt_in;
         end
      end
      if (ph_ff) begin
         otk_ff <= tk; otg_ff <= tg; ost_ff <= st;
         if (do_push) stk_ff[top_ff] <= push_v;
         if (q_wr) begin
            qdi_ff[tail_slot] <= {idx_ff, tk};
            qact_mem[tail_slot] <= act;
            qpop_mem[tail_slot] <= popv;
         end
      end
   end

   // table writes: clear sweep or trained entry
   always_ff @(posedge clock) begin
      if (clearing) begin
         ctr_mem[clr_ff[IndexBits-1:0]] <= CounterInit;
         tgt_mem[clr_ff[IndexBits-1:0]] <= '0;
      end else if (ph_ff) begin
         if (c_wr) ctr_mem[uidx] <= cnew;
         if (t_wr) tgt_mem[uidx] <= it_ff.actual_target;
      end
   end
endmodule

@@ design/gshare_branch_predictor_ras.sv @@
// Gshare predictor with target table, 8-entry return stack and 32-entry fetch
// target queue. Items enter a two-entry front queue; the back part takes one
// item at a time in two phases (registered table/queue read, then execute), and
// takes no new item while busy or while a result is stalled. After reset a clear
// sweep initializes the tables before the first item executes. Depends on gbp_pkg.
`include "gshare_branch_predictor_ras_assert.svh"
module gshare_branch_predictor_ras (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_address,
   input  logic [1:0]  req_branch_type,
   input  logic [63:0] req_known_offset,
   input  logic        req_actual_taken,
   input  logic [63:0] req_actual_target,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_predicted_taken,
   output logic [63:0] rsp_predicted_target,
   output logic [1:0]  rsp_status
);
   import gbp_pkg::*;
   item_type in_item, q_item;
   logic q_valid, q_take, busy;

   always_comb begin
      in_item.op = op_type'(req_op);
      in_item.address = req_address;
      in_item.btype = branch_type'(req_branch_type);
      in_item.offset = req_known_offset;
      in_item.actual_taken = req_actual_taken;
      in_item.actual_target = req_actual_target;
   end

   gbp_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall), .in_item,
      .out_valid(q_valid), .out_take(q_take), .out_item(q_item)
   );

   gbp_back u_back (
      .clock, .reset, .in_valid(q_valid), .in_take(q_take), .in_item(q_item),
      .rsp_valid, .rsp_stall, .rsp_predicted_taken, .rsp_predicted_target,
      .rsp_status, .busy
   );

   `GBP_ASSERT(a_ok_status, clock, reset, rsp_valid |-> rsp_status != ST_RSVD, "bad status")
   `GBP_ASSERT(a_err_zero, clock, reset, (rsp_valid && rsp_status != ST_OK) |-> !rsp_predicted_taken, "error with taken")
   `GBP_ASSERT(a_busy_no_take, clock, reset, busy |-> !q_take, "item taken while busy")
   `GBP_ASSERT_RST(a_reset_idle, clock, reset |=> !rsp_valid, "valid after reset")
endmodule

@@ tb/gshare_branch_predictor_ras_test.sv @@
// Self-checking testbench for the gshare predictor with return stack and fetch queue.
// Carries its own predictor of the block and compares every result item against it.
// Depends on gbp_pkg and gshare_branch_predictor_ras.
`timescale 1ns / 1ps
module gshare_branch_predictor_ras_test;
   import gbp_pkg::*;

   localparam int NumRandom = 1600;
   localparam int IdleLimit = 3000;
   localparam int LongHold  = 300;

   typedef struct {
      logic        taken;
      logic [63:0] target;
      status_type  status;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = '0;
   logic [63:0] req_address = '0;
   logic [1:0]  req_branch_type = '0;
   logic [63:0] req_known_offset = '0;
   logic        req_actual_taken = 1'b0;
   logic [63:0] req_actual_target = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_predicted_taken;
   logic [63:0] rsp_predicted_target;
   logic [1:0]  rsp_status;

   gshare_branch_predictor_ras dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [CounterBits-1:0] dir_ctr [TableSize];
   logic [63:0]            btb [TableSize];
   logic [HistBits-1:0]    ghist;
   logic [63:0]            ras [StackDepth];
   int                     ras_top, ras_cnt;
   logic [IndexBits:0]     ftq_dir_idx [QueueDepth];
   act_type                ftq_act [QueueDepth];
   logic [63:0]            ftq_popped [QueueDepth];
   int                     ftq_head, ftq_cnt;

   item_type    pending_items[$];
   outcome_type expected_outcomes[$];
   int          mismatches = 0;
   int          outcomes_seen = 0;
   int          idle_cycles = 0;
   int          gen_ftq_cnt = 0;   // queue occupancy as the stimulus generator sees it
   logic [63:0] hot_addr [8];

   function automatic void ras_push(logic [63:0] a);
      ras[ras_top] = a;
      ras_top = (ras_top + 1) % StackDepth;
      if (ras_cnt < StackDepth) ras_cnt++;
   endfunction

   function automatic logic [63:0] ras_pop();
      ras_top = (ras_top + StackDepth - 1) % StackDepth;
      ras_cnt--;
      return ras[ras_top];
   endfunction

   function automatic outcome_type gshare_step(item_type it);
      outcome_type r;
      logic [IndexBits-1:0] idx;
      logic tk, prev;
      logic [63:0] tgt, popped;
      act_type act;
      int slot;
      logic [CounterBits-1:0] c;
      r.taken = 1'b0;
      r.target = '0;
      r.status = ST_OK;
      case (it.op)
         OP_PREDICT: begin
            if (ftq_cnt >= QueueDepth) begin
               r.status = ST_FULL;
            end else begin
               idx = IndexBits'((it.address >> 2) ^ 64'(ghist));
               tk = dir_ctr[idx] >= WeakTaken;
               tgt = (it.offset != 0) ? it.address + it.offset : btb[idx];
               act = ACT_NONE;
               popped = '0;
               slot = (ftq_head + ftq_cnt) % QueueDepth;
               case (it.btype)
                  BR_UNCOND: tk = 1'b1;
                  BR_RETURN: begin
                     tk = 1'b1;
                     if (ras_cnt > 0) begin
                        popped = ras_pop();
                        tgt = popped;
                        act = ACT_POP;
                     end
                  end
                  BR_CALL: begin
                     tk = 1'b1;
                     ras_push(it.address + 64'd4);
                     act = ACT_PUSH;
                  end
                  default: if (!tk) tgt = it.address + 64'd4;
               endcase
               ftq_dir_idx[slot] = {idx, tk};
               ftq_act[slot] = act;
               ftq_popped[slot] = popped;
               ftq_cnt++;
               ghist = {ghist[HistBits-2:0], tk};
               r.taken = tk;
               r.target = tgt;
            end
         end
         OP_UPDATE: begin
            if (ftq_cnt == 0) begin
               r.status = ST_EMPTY;
            end else begin
               prev = ftq_dir_idx[ftq_head][0];
               idx = ftq_dir_idx[ftq_head][IndexBits:1];
               c = dir_ctr[idx];
               ftq_head = (ftq_head + 1) % QueueDepth;
               ftq_cnt--;
               if (it.actual_taken) begin
                  if (c != CounterMax) c++;
                  btb[idx] = it.actual_target;
               end else if (c != 0) begin
                  c--;
               end
               dir_ctr[idx] = c;
               if (prev != it.actual_taken && ftq_cnt < HistBits)
                  ghist[ftq_cnt] = ~ghist[ftq_cnt];
            end
         end
         OP_FLUSH: begin
            if (ftq_cnt == 0) begin
               r.status = ST_EMPTY;
            end else begin
               slot = (ftq_head + ftq_cnt - 1) % QueueDepth;
               if (ftq_act[slot] == ACT_POP) ras_push(ftq_popped[slot]);
               else if (ftq_act[slot] == ACT_PUSH && ras_cnt > 0) void'(ras_pop());
               ftq_cnt--;
               ghist = ghist >> 1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic add_item(op_type op, logic [63:0] a, branch_type bt, logic [63:0] off,
                           logic tk, logic [63:0] tgt);
      item_type it;
      it.op = op;
      it.address = a;
      it.btype = bt;
      it.offset = off;
      it.actual_taken = tk;
      it.actual_target = tgt;
      pending_items = {pending_items, it};
      if (op == OP_PREDICT && gen_ftq_cnt < QueueDepth) gen_ftq_cnt++;
      else if (op != OP_PREDICT && gen_ftq_cnt > 0) gen_ftq_cnt--;
   endtask

   task automatic add_random(op_type op);
      logic [63:0] a, off;
      case ($urandom_range(0, 3))
         0: a = rand64();
         1: a = {$urandom_range(0, 15), 2'b00};
         default: a = hot_addr[$urandom_range(0, 7)] ^ 64'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 5))
         0: off = rand64();
         1: off = 64'(signed'($urandom_range(0, 512)) - 256);
         default: off = '0;
      endcase
      add_item(op, a, branch_type'($urandom_range(0, 3)), off, 1'($urandom), rand64());
   endtask

   initial begin
      int burst;
      for (int i = 0; i < TableSize; i++) begin
         dir_ctr[i] = CounterInit;
         btb[i] = '0;
      end
      ghist = '0;
      ras_top = 0;
      ras_cnt = 0;
      ftq_head = 0;
      ftq_cnt = 0;
      for (int i = 0; i < 8; i++) hot_addr[i] = rand64();

      // directed: empty queue errors, field extremes, stack underflow and overflow
      add_item(OP_UPDATE, '0, BR_COND, '0, 1'b1, '1);
      add_item(OP_FLUSH, '0, BR_COND, '0, 1'b0, '0);
      add_item(OP_PREDICT, '0, BR_COND, '0, 1'b0, '0);
      add_item(OP_PREDICT, '1, BR_COND, '1, 1'b0, '0);
      add_item(OP_PREDICT, 64'h1000, BR_UNCOND, 64'h8000_0000_0000_0000, 1'b0, '0);
      add_item(OP_PREDICT, '1, BR_UNCOND, 64'h7fff_ffff_ffff_ffff, 1'b0, '0);
      add_item(OP_PREDICT, 64'h2000, BR_RETURN, '0, 1'b0, '0);
      for (int i = 0; i < 9; i++)
         add_item(OP_PREDICT, 64'h4000 + 64'(i * 16), BR_CALL, '0, 1'b0, '0);
      add_item(OP_PREDICT, 64'h3000, BR_RETURN, 64'h40, 1'b0, '0);
      add_item(OP_FLUSH, '0, BR_COND, '0, 1'b0, '0);
      add_item(OP_FLUSH, '0, BR_COND, '0, 1'b0, '0);
      add_item(OP_UPDATE, '0, BR_COND, '0, 1'b1, '1);
      add_item(OP_UPDATE, '0, BR_COND, '0, 1'b0, '0);
      add_item(OP_UPDATE, '0, BR_COND, '0, 1'b1, 64'h5555_aaaa_5555_aaaa);

      // random: mostly balanced traffic, with bursts that fill or drain the queue
      for (int n = 0; n < NumRandom; ) begin
         case ($urandom_range(0, 9))
            0: begin
               burst = $urandom_range(30, 40);
               repeat (burst) add_random(OP_PREDICT);
               n += burst;
            end
            1: begin
               burst = $urandom_range(gen_ftq_cnt, gen_ftq_cnt + 3);
               repeat (burst) add_random(($urandom_range(0, 3) == 0) ? OP_FLUSH : OP_UPDATE);
               n += burst;
            end
            default: begin
               burst = $urandom_range(4, 16);
               repeat (burst) begin
                  if (gen_ftq_cnt < 4) add_random(($urandom_range(0, 4) != 0) ? OP_PREDICT
                                                                           : OP_UPDATE);
                  else case ($urandom_range(0, 5))
                     0, 1, 2: add_random(OP_PREDICT);
                     3, 4: add_random(OP_UPDATE);
                     default: add_random(OP_FLUSH);
                  endcase
               end
               n += burst;
            end
         endcase
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending_items.size() != 0 || req_valid || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // driver
   item_type cur_item;
   int       send_gap = 0;
   logic     send_burst = 1'b0;
   always @(posedge clock) begin
      logic accepted, next_valid;
      accepted = req_valid && !req_stall;
      next_valid = req_valid;
      if (!reset) begin
         if (accepted) expected_outcomes = {expected_outcomes, gshare_step(cur_item)};
         if (!req_valid || accepted) begin
            if (send_gap > 0) begin
               send_gap--;
               next_valid = 1'b0;
            end else if (pending_items.size() != 0) begin
               cur_item = pending_items[0];
               pending_items.delete(0);
               req_op <= cur_item.op;
               req_address <= cur_item.address;
               req_branch_type <= cur_item.btype;
               req_known_offset <= cur_item.offset;
               req_actual_taken <= cur_item.actual_taken;
               req_actual_target <= cur_item.actual_target;
               next_valid = 1'b1;
               if ($urandom_range(0, 31) == 0) send_burst = ~send_burst;
               send_gap = send_burst ? 0 : $urandom_range(0, 12);
            end else begin
               next_valid = 1'b0;
            end
         end
         req_valid <= next_valid;
      end
   end

   // monitor and checker
   int recv_wait = 0;
   always @(posedge clock) begin
      outcome_type want;
      logic next_stall;
      next_stall = rsp_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            outcomes_seen++;
            if (expected_outcomes.size() == 0) begin
               $error("result item with nothing expected");
               mismatches++;
            end else begin
               want = expected_outcomes[0];
               expected_outcomes.delete(0);
               if (rsp_predicted_taken !== want.taken) begin
                  $error("predicted_taken expected %0d actual %0d", want.taken,
                         rsp_predicted_taken);
                  mismatches++;
               end
               if (rsp_predicted_target !== want.target) begin
                  $error("predicted_target expected %h actual %h", want.target,
                         rsp_predicted_target);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  mismatches++;
               end
            end
            // one long hold-off so the block backs up into its input
            recv_wait = (outcomes_seen == 400) ? LongHold
                      : (outcomes_seen % 200 < 60) ? 0 : $urandom_range(0, 12);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            next_stall = 1'b1;
         end else begin
            next_stall = 1'b0;
         end
         rsp_stall <= next_stall;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end
endmodule
